@@ rtl/ecs_pkg.sv @@
package ecs_pkg;

    // Coordinate width and the widths that follow from it
    localparam int CoordBits = 16;
    localparam int MagBits   = CoordBits + 1;
    localparam int SpanBits  = CoordBits + 1;
    localparam int ErrBits   = CoordBits + 3;
    localparam int CntBits   = $clog2(CoordBits + 1);
    localparam int AxisCount = 3;

    typedef logic signed [CoordBits-1:0] coord_t;
    typedef logic [MagBits-1:0]          mag_t;
    typedef logic [SpanBits-1:0]         span_t;
    typedef logic signed [ErrBits-1:0]   err_t;
    typedef logic [CntBits-1:0]          cnt_t;
    typedef logic [1:0]                  axis_t;

    // Axis codes, also the bit positions in the direction word
    localparam axis_t AxisDestX = 2'd0;
    localparam axis_t AxisSrcX  = 2'd1;
    localparam axis_t AxisSrcY  = 2'd2;

    // Item kinds
    localparam logic KindLoad = 1'b0;
    localparam logic KindStep = 1'b1;

endpackage

@@ rtl/ecs_if.sv @@
interface ecs_cmd_if;
    logic                valid;
    logic                ready;
    logic                kind;
    logic                emit_start;
    ecs_pkg::coord_t     dest_x_start;
    ecs_pkg::coord_t     dest_y_start;
    ecs_pkg::coord_t     dest_x_end;
    ecs_pkg::coord_t     dest_y_end;
    ecs_pkg::coord_t     src_x_start;
    ecs_pkg::coord_t     src_y_start;
    ecs_pkg::coord_t     src_x_end;
    ecs_pkg::coord_t     src_y_end;

    modport source
    (
        output valid, kind, emit_start, dest_x_start, dest_y_start, dest_x_end, dest_y_end,
        output src_x_start, src_y_start, src_x_end, src_y_end,
        input  ready
    );
    modport sink
    (
        input  valid, kind, emit_start, dest_x_start, dest_y_start, dest_x_end, dest_y_end,
        input  src_x_start, src_y_start, src_x_end, src_y_end,
        output ready
    );
endinterface

interface ecs_row_if;
    logic                valid;
    logic                ready;
    ecs_pkg::coord_t     row_dest_x;
    ecs_pkg::coord_t     row_src_x;
    ecs_pkg::coord_t     row_src_y;
    logic                last_row;

    modport source
    (
        output valid, row_dest_x, row_src_x, row_src_y, last_row,
        input  ready
    );
    modport sink
    (
        input  valid, row_dest_x, row_src_x, row_src_y, last_row,
        output ready
    );
endinterface

@@ rtl/edge_coordinate_stepper.sv @@
// Channel  Dir   Beat contents
// -------  ----  ------------------------------------------------------------
// cmd      in    kind, emit_start, destination and texture end points
// row      out   row_dest_x, row_src_x, row_src_y, last_row
//
// A load beat passes through accept, delta set-up and error set-up.
// A step beat checks the axes in turn and then emits its row: each
// of the three axes whose error term is positive runs the shared radix-2
// divider (one quotient bit a cycle) to find its advance count.
// Reset clears the sequencer, the output valid and all edge state; no edge is
// active afterwards. A stalled row beat holds in the output register; the
// block still accepts the next cmd beat and only waits when it must write a
// new row while the previous one is still unclaimed.
module edge_coordinate_stepper
(
    input  logic         clk,
    input  logic         rst_n,
    ecs_cmd_if.sink      cmd,
    ecs_row_if.source    row
);

    localparam int N = ecs_pkg::CoordBits;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_LOAD,
        ST_LOAD_ERR,
        ST_CHECK,
        ST_DIV,
        ST_APPLY,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;

    // Latched load beat
    logic                emit_reg, emit_next;
    ecs_pkg::coord_t     ld_coord_reg [8];
    ecs_pkg::coord_t     ld_coord_next [8];

    // Edge state, one entry per axis
    ecs_pkg::coord_t     cur_reg [ecs_pkg::AxisCount];
    ecs_pkg::coord_t     cur_next [ecs_pkg::AxisCount];
    ecs_pkg::err_t       err_reg [ecs_pkg::AxisCount];
    ecs_pkg::err_t       err_next [ecs_pkg::AxisCount];
    ecs_pkg::mag_t       mag_reg [ecs_pkg::AxisCount];
    ecs_pkg::mag_t       mag_next [ecs_pkg::AxisCount];
    logic [ecs_pkg::AxisCount-1:0] dir_reg, dir_next;
    ecs_pkg::span_t      row_span_reg, row_span_next;
    ecs_pkg::span_t      rows_left_reg, rows_left_next;

    // Shared divider
    ecs_pkg::axis_t      axis_reg, axis_next;
    ecs_pkg::cnt_t       cnt_reg, cnt_next;
    ecs_pkg::span_t      rem_reg, rem_next;
    logic [N-1:0]        quo_reg, quo_next;

    // Output register
    logic                out_valid_reg, out_valid_next;
    ecs_pkg::coord_t     out_dest_x_reg, out_dest_x_next;
    ecs_pkg::coord_t     out_src_x_reg, out_src_x_next;
    ecs_pkg::coord_t     out_src_y_reg, out_src_y_next;
    logic                out_last_reg, out_last_next;

    logic                cmd_fire;
    logic                out_free;
    logic [N:0]          delta [4];
    logic [N:0]          trial;
    logic                trial_ge;
    ecs_pkg::err_t       err_sel;
    logic [N-1:0]        adv;
    ecs_pkg::err_t       dividend;

    assign cmd.ready  = (state_reg == ST_IDLE);
    assign cmd_fire   = cmd.valid && cmd.ready;
    assign out_free   = !out_valid_reg || row.ready;

    assign row.valid      = out_valid_reg;
    assign row.row_dest_x = out_dest_x_reg;
    assign row.row_src_x  = out_src_x_reg;
    assign row.row_src_y  = out_src_y_reg;
    assign row.last_row   = out_last_reg;

    // Signed end minus start: dest x, src x, src y, dest y
    always_comb
    begin
        delta[0] = {ld_coord_reg[2][N-1], ld_coord_reg[2]} - {ld_coord_reg[0][N-1], ld_coord_reg[0]};
        delta[1] = {ld_coord_reg[6][N-1], ld_coord_reg[6]} - {ld_coord_reg[4][N-1], ld_coord_reg[4]};
        delta[2] = {ld_coord_reg[7][N-1], ld_coord_reg[7]} - {ld_coord_reg[5][N-1], ld_coord_reg[5]};
        delta[3] = {ld_coord_reg[3][N-1], ld_coord_reg[3]} - {ld_coord_reg[1][N-1], ld_coord_reg[1]};
    end

    // One restoring division step on the shared unit
    assign err_sel  = err_reg[axis_reg];
    assign dividend = err_sel - ecs_pkg::err_t'(1);
    assign trial    = {rem_reg[N-1:0], quo_reg[N-1]};
    assign trial_ge = (trial >= row_span_reg);
    assign adv      = quo_reg + N'(1);

    always_comb
    begin
        state_next     = state_reg;
        emit_next      = emit_reg;
        ld_coord_next  = ld_coord_reg;
        cur_next       = cur_reg;
        err_next       = err_reg;
        mag_next       = mag_reg;
        dir_next       = dir_reg;
        row_span_next  = row_span_reg;
        rows_left_next = rows_left_reg;
        axis_next      = axis_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        out_valid_next = out_valid_reg && !row.ready;
        out_dest_x_next = out_dest_x_reg;
        out_src_x_next  = out_src_x_reg;
        out_src_y_next  = out_src_y_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    if (cmd.kind == ecs_pkg::KindLoad)
                    begin
                        emit_next        = cmd.emit_start;
                        ld_coord_next[0] = cmd.dest_x_start;
                        ld_coord_next[1] = cmd.dest_y_start;
                        ld_coord_next[2] = cmd.dest_x_end;
                        ld_coord_next[3] = cmd.dest_y_end;
                        ld_coord_next[4] = cmd.src_x_start;
                        ld_coord_next[5] = cmd.src_y_start;
                        ld_coord_next[6] = cmd.src_x_end;
                        ld_coord_next[7] = cmd.src_y_end;
                        state_next       = ST_LOAD;
                    end
                    else if (rows_left_reg != '0)
                    begin
                        axis_next  = ecs_pkg::AxisDestX;
                        state_next = ST_CHECK;
                    end
                end
            end

            ST_LOAD:
            begin
                // Latch start point, magnitudes, directions and row count
                cur_next[ecs_pkg::AxisDestX] = ld_coord_reg[0];
                cur_next[ecs_pkg::AxisSrcX]  = ld_coord_reg[4];
                cur_next[ecs_pkg::AxisSrcY]  = ld_coord_reg[5];
                for (int a = 0; a < ecs_pkg::AxisCount; a++)
                begin
                    dir_next[a] = delta[a][N];
                    mag_next[a] = delta[a][N] ? ecs_pkg::mag_t'(-delta[a])
                                              : ecs_pkg::mag_t'(delta[a]);
                end
                if (!delta[3][N] && delta[3] != '0)
                begin
                    row_span_next  = ecs_pkg::span_t'(delta[3]);
                    rows_left_next = ecs_pkg::span_t'(delta[3]);
                end
                else
                begin
                    row_span_next  = '0;
                    rows_left_next = '0;
                end
                state_next = ST_LOAD_ERR;
            end

            ST_LOAD_ERR:
            begin
                if (!emit_reg || out_free)
                begin
                    for (int a = 0; a < ecs_pkg::AxisCount; a++)
                    begin
                        err_next[a] = ecs_pkg::err_t'(mag_reg[a])
                                    - ecs_pkg::err_t'(row_span_reg >> 1);
                    end
                    if (emit_reg)
                    begin
                        out_valid_next  = 1'b1;
                        out_dest_x_next = cur_reg[ecs_pkg::AxisDestX];
                        out_src_x_next  = cur_reg[ecs_pkg::AxisSrcX];
                        out_src_y_next  = cur_reg[ecs_pkg::AxisSrcY];
                        out_last_next   = (rows_left_reg == '0);
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_CHECK:
            begin
                // Positive error: divide (err - 1) by the row count
                if (err_sel > ecs_pkg::err_t'(0))
                begin
                    quo_next   = dividend[N-1:0];
                    rem_next   = '0;
                    cnt_next   = ecs_pkg::cnt_t'(N);
                    state_next = ST_DIV;
                end
                else if (axis_reg == ecs_pkg::AxisSrcY)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    axis_next = axis_reg + 2'd1;
                end
            end

            ST_DIV:
            begin
                rem_next   = trial_ge ? (trial - row_span_reg) : trial;
                quo_next   = {quo_reg[N-2:0], trial_ge};
                cnt_next   = cnt_reg - ecs_pkg::cnt_t'(1);
                if (cnt_reg == ecs_pkg::cnt_t'(1))
                begin
                    state_next = ST_APPLY;
                end
            end

            ST_APPLY:
            begin
                // Advance by quotient + 1; error ends at rem + 1 - span
                cur_next[axis_reg] = dir_reg[axis_reg] ? (cur_reg[axis_reg] - adv)
                                                       : (cur_reg[axis_reg] + adv);
                err_next[axis_reg] = ecs_pkg::err_t'(rem_reg) + ecs_pkg::err_t'(1)
                                   - ecs_pkg::err_t'(row_span_reg);
                if (axis_reg == ecs_pkg::AxisSrcY)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = ST_CHECK;
                end
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_dest_x_next = cur_reg[ecs_pkg::AxisDestX];
                    out_src_x_next  = cur_reg[ecs_pkg::AxisSrcX];
                    out_src_y_next  = cur_reg[ecs_pkg::AxisSrcY];
                    out_last_next   = (rows_left_reg == ecs_pkg::span_t'(1));
                    rows_left_next  = rows_left_reg - ecs_pkg::span_t'(1);
                    for (int a = 0; a < ecs_pkg::AxisCount; a++)
                    begin
                        err_next[a] = err_reg[a] + ecs_pkg::err_t'(mag_reg[a]);
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int a = 0; a < ecs_pkg::AxisCount; a++)
            begin
                cur_reg[a] <= '0;
                err_reg[a] <= '0;
                mag_reg[a] <= '0;
            end
            dir_reg       <= '0;
            row_span_reg  <= '0;
            rows_left_reg <= '0;
            axis_reg      <= ecs_pkg::AxisDestX;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cur_reg       <= cur_next;
            err_reg       <= err_next;
            mag_reg       <= mag_next;
            dir_reg       <= dir_next;
            row_span_reg  <= row_span_next;
            rows_left_reg <= rows_left_next;
            axis_reg      <= axis_next;
            cnt_reg       <= cnt_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        emit_reg       <= emit_next;
        ld_coord_reg   <= ld_coord_next;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        out_dest_x_reg <= out_dest_x_next;
        out_src_x_reg  <= out_src_x_next;
        out_src_y_reg  <= out_src_y_next;
        out_last_reg   <= out_last_next;
    end

    // Remainder stays below the row count throughout a division
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV || state_reg == ST_APPLY) |-> rem_reg < row_span_reg)
        else $error("divider remainder not below row count");

    // A division only runs with bits left to produce
    a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> cnt_reg != '0)
        else $error("divider running with zero count");

    // Rows still to emit never exceed the edge's row count
    a_rows_left: assert property (@(posedge clk) disable iff (!rst_n)
        rows_left_reg <= row_span_reg)
        else $error("rows left exceeds row span");

    // A step on an exhausted edge is dropped at once
    a_idle_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_fire && cmd.kind == ecs_pkg::KindStep && rows_left_reg == '0)
        |=> state_reg == ST_IDLE && $stable(rows_left_reg))
        else $error("step without rows did not stay idle");

endmodule
